/* src/mkd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared constants, letter code tables, the inter-module letter struct and
// the pattern match function.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int MAX_SYMBOLS = 5;
  localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [CNT_W-1:0] DASH_RESET = 16'd250;
  localparam logic [CNT_W-1:0] GAP_RESET  = 16'd500;

  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DASH_TICKS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS  = 1'b1;

  localparam int IDX_W = 5;
  localparam int COL_W = 7;
  localparam int ROW_W = 3;
  localparam logic [COL_W-1:0] COL_LIMIT = 7'(14 * 6 - 1);
  localparam logic [COL_W-1:0] COL_STEP  = 7'd6;
  localparam logic [COL_W-1:0] COL_HOME  = 7'd1;
  localparam logic [ROW_W-1:0] ROW_LIMIT = 3'd5;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRESS = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;

  localparam int LETTERS = 26;

  // Code length and pattern of A to Z; bit i of the pattern is symbol i,
  // with 1 meaning a dash.
  localparam logic [2:0] CODE_LEN [LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] CODE_BITS [LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef struct packed {
    logic                   done;
    logic                   overflow;
    logic [SYM_CNT_W-1:0]   count;
    logic [MAX_SYMBOLS-1:0] bits;
  } letter_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } match_t;

  // Lowest matching letter wins, so the scan runs from Z down to A.
  function automatic match_t match_letter(input logic [SYM_CNT_W-1:0] count,
                                          input logic [MAX_SYMBOLS-1:0] bits);
    match_t m;
    m = '0;
    for (int k = LETTERS - 1; k >= 0; k--) begin
      if (count == SYM_CNT_W'(CODE_LEN[k]) && bits == MAX_SYMBOLS'(CODE_BITS[k])) begin
        m.hit = 1'b1;
        m.idx = IDX_W'(k);
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* src/morse_key_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder top level
// Turns one key sample per tick into decoded letters with display positions.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one key sample (button_pressed) per transfer,
// normally one per millisecond tick. A transfer happens on a rising edge with
// in_valid high and in_stall low. The output channel carries one result per
// finished letter: letter_valid, letter_index (0 = A), and the column and row
// where the letter goes; a transfer happens with out_valid high and out_stall
// low. Most samples produce no result.
// Each sample is held in an input register and then processed in a single
// pass into the output register, from which its result can transfer. One
// sample is accepted per cycle while in_stall is low.
// When the receiver stalls, the held result stays put and samples keep
// flowing; only a sample that would end another letter waits in the input
// register, and then in_stall rises until the output register frees up.
// Reset clears the timing state, sets the cursor to column 1, row 0, and loads
// 250 (dash) and 500 (gap) ticks; the user must write these thresholds through
// cfg_we/cfg_index/cfg_data while no letter is pending; nothing enforces it.
// ----------------------------------------------------------------------------
module morse_key_decoder_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            button_pressed,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 letter_valid,
  output logic [mkd_pkg::IDX_W-1:0]            letter_index,
  output logic [mkd_pkg::COL_W-1:0]            column,
  output logic [mkd_pkg::ROW_W-1:0]            row,
  input  wire logic                            cfg_we,
  input  wire logic [mkd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mkd_pkg::CFG_W-1:0]       cfg_data
);

  logic [mkd_pkg::CNT_W-1:0] dash_ticks;
  logic [mkd_pkg::CNT_W-1:0] gap_ticks;

  // Input register.
  logic in_full;
  logic in_pressed;

  mkd_pkg::letter_t          letter;
  logic                      step;
  logic                      in_take;

  logic                      match_valid;
  logic [mkd_pkg::IDX_W-1:0] match_index;
  logic [mkd_pkg::COL_W-1:0] place_column;
  logic [mkd_pkg::ROW_W-1:0] place_row;

  // The held sample moves on unless it finishes a letter while the output
  // register still holds an untaken result.
  assign step     = in_full && !(letter.done && out_valid && out_stall);
  assign in_stall = in_full && !step;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_ticks <= mkd_pkg::DASH_RESET;
      gap_ticks  <= mkd_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkd_pkg::CFG_DASH_TICKS: dash_ticks <= cfg_data;
        mkd_pkg::CFG_GAP_TICKS:  gap_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pressed <= button_pressed;
    end
  end

  mkd_key_timer u_timer (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pressed    (in_pressed),
    .dash_ticks (dash_ticks),
    .gap_ticks  (gap_ticks),
    .letter     (letter)
  );

  mkd_letter_place u_place (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .letter       (letter),
    .letter_valid (match_valid),
    .letter_index (match_index),
    .column       (place_column),
    .row          (place_row)
  );

  // Output register: loaded when a letter ends, cleared once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && letter.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && letter.done) begin
      letter_valid <= match_valid;
      letter_index <= match_index;
      column       <= place_column;
      row          <= place_row;
    end
  end

endmodule
`default_nettype wire

/* src/mkd_key_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key timer
// Times presses and releases, collects dots and dashes and flags the tick
// on which a letter ends.
// ----------------------------------------------------------------------------
module mkd_key_timer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic                      pressed,
  input  wire logic [mkd_pkg::CNT_W-1:0] dash_ticks,
  input  wire logic [mkd_pkg::CNT_W-1:0] gap_ticks,
  output mkd_pkg::letter_t               letter
);

  logic [1:0]                         phase, phase_next;
  logic [mkd_pkg::CNT_W-1:0]          press_count, press_count_next;
  logic [mkd_pkg::CNT_W-1:0]          gap_count, gap_count_next;
  logic [mkd_pkg::SYM_CNT_W-1:0]      symbol_count, symbol_count_next;
  logic [mkd_pkg::MAX_SYMBOLS-1:0]    symbol_bits, symbol_bits_next;
  logic                               overflow_flag, overflow_flag_next;

  logic [mkd_pkg::SYM_CNT_W-1:0]      sc;
  logic [mkd_pkg::MAX_SYMBOLS-1:0]    sb;
  logic                               ov;
  logic [mkd_pkg::CNT_W-1:0]          gc;
  logic                               done;

  always_comb begin
    phase_next         = phase;
    press_count_next   = press_count;
    gap_count_next     = gap_count;
    symbol_count_next  = symbol_count;
    symbol_bits_next   = symbol_bits;
    overflow_flag_next = overflow_flag;
    sc   = symbol_count;
    sb   = symbol_bits;
    ov   = overflow_flag;
    gc   = gap_count;
    done = 1'b0;

    if (pressed) begin
      if (phase == mkd_pkg::PH_PRESS) begin
        if (press_count != mkd_pkg::CNT_MAX) begin
          press_count_next = press_count + 1'b1;
        end
      end else begin
        phase_next       = mkd_pkg::PH_PRESS;
        press_count_next = 16'd1;
        gap_count_next   = '0;
      end
    end else if (phase != mkd_pkg::PH_IDLE) begin
      // The release tick appends the symbol, then counts as the first gap tick.
      if (phase == mkd_pkg::PH_PRESS) begin
        if (symbol_count < mkd_pkg::SYM_CNT_W'(mkd_pkg::MAX_SYMBOLS)) begin
          if (press_count >= dash_ticks) begin
            sb[symbol_count[mkd_pkg::SYM_IDX_W-1:0]] = 1'b1;
          end
          sc = symbol_count + 1'b1;
        end else begin
          ov = 1'b1;
        end
        gc = '0;
      end
      if (gc != mkd_pkg::CNT_MAX) begin
        gc = gc + 1'b1;
      end
      done = (gc >= gap_ticks);

      if (done) begin
        phase_next         = mkd_pkg::PH_IDLE;
        press_count_next   = '0;
        gap_count_next     = '0;
        symbol_count_next  = '0;
        symbol_bits_next   = '0;
        overflow_flag_next = 1'b0;
      end else begin
        phase_next         = mkd_pkg::PH_GAP;
        press_count_next   = '0;
        gap_count_next     = gc;
        symbol_count_next  = sc;
        symbol_bits_next   = sb;
        overflow_flag_next = ov;
      end
    end

    letter.done     = done;
    letter.overflow = ov;
    letter.count    = sc;
    letter.bits     = sb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mkd_pkg::PH_IDLE;
      press_count   <= '0;
      gap_count     <= '0;
      symbol_count  <= '0;
      symbol_bits   <= '0;
      overflow_flag <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      press_count   <= press_count_next;
      gap_count     <= gap_count_next;
      symbol_count  <= symbol_count_next;
      symbol_bits   <= symbol_bits_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule
`default_nettype wire

/* src/mkd_letter_place.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse letter placement
// Matches a finished symbol pattern against A to Z and keeps the display
// cursor, moving it on every matched letter.
// ----------------------------------------------------------------------------
module mkd_letter_place (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire mkd_pkg::letter_t          letter,
  output logic                           letter_valid,
  output logic [mkd_pkg::IDX_W-1:0]      letter_index,
  output logic [mkd_pkg::COL_W-1:0]      column,
  output logic [mkd_pkg::ROW_W-1:0]      row
);

  logic [mkd_pkg::COL_W-1:0] cursor_column, cursor_column_next;
  logic [mkd_pkg::ROW_W-1:0] cursor_row, cursor_row_next;
  mkd_pkg::match_t           m;

  always_comb begin
    m            = mkd_pkg::match_letter(letter.count, letter.bits);
    letter_valid = m.hit && !letter.overflow;
    letter_index = letter_valid ? m.idx : '0;
    column       = cursor_column;
    row          = cursor_row;

    // Past the last column the cursor returns home on the next row.
    if (cursor_column > mkd_pkg::COL_LIMIT) begin
      cursor_column_next = mkd_pkg::COL_HOME;
      cursor_row_next    = (cursor_row > mkd_pkg::ROW_LIMIT) ? '0 : cursor_row + 1'b1;
    end else begin
      cursor_column_next = cursor_column + mkd_pkg::COL_STEP;
      cursor_row_next    = cursor_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= mkd_pkg::COL_HOME;
      cursor_row    <= '0;
    end else if (step && letter.done && letter_valid) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule
`default_nettype wire
